### rtl/wsff_pi_pkg.sv
`timescale 1ns / 1ps

package wsff_pi_pkg;

  // Field and datapath widths (all fixed by the field formats)
  localparam int TGT_W    = 16;   // target, integer ticks/s
  localparam int MEAS_W   = 20;   // measured speed, Q.4
  localparam int ERR_W    = 21;   // error, Q.4
  localparam int GAIN_W   = 24;   // gains, unsigned Q8.16
  localparam int ICPT_W   = 26;   // intercept, unsigned Q.16
  localparam int LIM_W    = 10;   // per-mille limits
  localparam int DUTY_W   = 11;   // signed per-mille duty
  localparam int INTEG_W  = 28;   // integrator, signed Q.16
  localparam int KFF_W    = 41;   // kff * target
  localparam int PROD_W   = 46;   // gain * error, Q.20
  localparam int STEP_W   = 42;   // integrator step, Q.16
  localparam int FFP_W    = 48;   // feedforward plus proportional, Q.20
  localparam int INEXT_W  = 43;   // integrator candidate, Q.16
  localparam int SUM_W    = 50;   // candidate and final sums, Q.20
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  localparam logic [LIM_W-1:0] LIMIT_RST = LIM_W'(1000);

  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KFF        = 3'd0,
    REG_INTERCEPT  = 3'd1,
    REG_PROP       = 3'd2,
    REG_INTEG_GAIN = 3'd3,
    REG_DUTY_LIM   = 3'd4,
    REG_INTEG_LIM  = 3'd5
  } cfg_reg_e;

  // Per-item control carried from the product stage to the integrator stage
  typedef struct packed {
    logic upd;      // update with a nonzero target
    logic clr;      // clear integrator, duty and flag
    logic adv;      // integrator may advance
    logic err_pos;  // error above zero
    logic err_neg;  // error below zero
  } s1_ctrl_t;

endpackage

### rtl/wsff_pi_integ.sv
`timescale 1ns / 1ps

// Integrator update with conditional integration and clamping
module wsff_pi_integ (
  input  logic signed [wsff_pi_pkg::INTEG_W-1:0] integ_i,
  input  logic signed [wsff_pi_pkg::FFP_W-1:0]   ffp_i,
  input  logic signed [wsff_pi_pkg::STEP_W-1:0]  step_i,
  input  wsff_pi_pkg::s1_ctrl_t                  ctrl_i,
  input  logic [wsff_pi_pkg::LIM_W-1:0]          duty_limit_i,
  input  logic [wsff_pi_pkg::LIM_W-1:0]          integ_limit_i,
  output logic signed [wsff_pi_pkg::INTEG_W-1:0] integ_o
);
  import wsff_pi_pkg::*;

  logic signed [INEXT_W-1:0] i_next;
  logic signed [INEXT_W-1:0] ilim;
  logic signed [INEXT_W-1:0] i_clamped;
  logic signed [SUM_W-1:0]   cand;
  logic signed [SUM_W-1:0]   dlim;
  logic                      hold;

  // Candidate integrator and the duty it would give
  assign i_next = INEXT_W'(integ_i) + INEXT_W'(step_i);
  assign cand   = SUM_W'(ffp_i) + (SUM_W'(i_next) <<< 4);
  assign dlim   = $signed({{(SUM_W-LIM_W-20){1'b0}}, duty_limit_i, 20'b0});
  assign ilim   = $signed({{(INEXT_W-LIM_W-16){1'b0}}, integ_limit_i, 16'b0});

  // Hold when the step would push further past the duty limit
  assign hold = ((cand > dlim) && ctrl_i.err_pos) || ((cand < -dlim) && ctrl_i.err_neg);

  always_comb begin
    i_clamped = i_next;
    if (i_next > ilim) begin
      i_clamped = ilim;
    end
    if (i_next < -ilim) begin
      i_clamped = -ilim;
    end
  end

  always_comb begin
    integ_o = integ_i;
    if (ctrl_i.clr) begin
      integ_o = '0;
    end else if (ctrl_i.upd && ctrl_i.adv && !hold) begin
      integ_o = INTEG_W'(i_clamped);
    end
  end

endmodule

### rtl/wheel_speed_ff_pi_top.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                     | Payload
// ----------+-----------+-------------------------------+---------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready | tdata: target, measured, enable
//           |           |                               | tuser: command
// m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata: duty, saturated
// cfg       | in        | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// One request accepted per cycle while no stall holds the pipeline; each gives one result.
// Stage one forms the three products, stage two closes the integrator loop, stage three
// rounds and clamps the duty into the output register.
// rst_ni clears gains, limits (to 1000), target, integrator, duty and flag.
// Each stage moves on when the next one is empty or moving, so bubbles fill during a stall.
// Configuration writes are always taken (cfg_ready_o high).
module wheel_speed_ff_pi_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: target_speed [15:0], measured_speed [35:16], advance_enable [36], zero pad
  input  logic [39:0]                         s_axis_tdata,
  // tuser: command [1:0]
  input  logic [1:0]                          s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: duty [10:0], saturated [11], zero pad
  output logic [15:0]                         m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wsff_pi_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [wsff_pi_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import wsff_pi_pkg::*;

  // Configuration registers
  logic [GAIN_W-1:0] kff_q, prop_q, igain_q;
  logic [ICPT_W-1:0] icpt_q;
  logic [LIM_W-1:0]  dlim_q, ilim_q;

  // Loop state
  logic signed [TGT_W-1:0]   target_q;
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic signed [DUTY_W-1:0]  duty_q, duty_d;
  logic                      sat_q, sat_d;

  // Stage registers
  logic                      s0_v_q, s1_v_q, s2_v_q, out_v_q;
  cmd_e                      s0_cmd_q;
  logic signed [TGT_W-1:0]   s0_tgt_q;
  logic signed [MEAS_W-1:0]  s0_meas_q;
  logic                      s0_adv_q;
  s1_ctrl_t                  s1_ctrl_q, s1_ctrl_d;
  logic signed [FFP_W-1:0]   s1_ffp_q, s1_ffp_d;
  logic signed [STEP_W-1:0]  s1_step_q, s1_step_d;
  logic                      s2_upd_q, s2_clr_q;
  logic signed [FFP_W-1:0]   s2_ffp_q;
  logic signed [INTEG_W-1:0] s2_integ_q;

  logic out_rdy, s2_rdy, s1_rdy, s0_rdy;
  logic s0_go, s1_go, s2_go;

  // Ready chain
  assign out_rdy       = !out_v_q || m_axis_tready;
  assign s2_rdy        = !s2_v_q || out_rdy;
  assign s1_rdy        = !s1_v_q || s2_rdy;
  assign s0_rdy        = !s0_v_q || s1_rdy;
  assign s0_go         = s0_v_q && s1_rdy;
  assign s1_go         = s1_v_q && s2_rdy;
  assign s2_go         = s2_v_q && out_rdy;
  assign s_axis_tready = s0_rdy;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'b0, sat_q, duty_q};
  assign cfg_ready_o   = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kff_q   <= '0;
      icpt_q  <= '0;
      prop_q  <= '0;
      igain_q <= '0;
      dlim_q  <= LIMIT_RST;
      ilim_q  <= LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_KFF:        kff_q   <= cfg_data_i[GAIN_W-1:0];
        REG_INTERCEPT:  icpt_q  <= cfg_data_i[ICPT_W-1:0];
        REG_PROP:       prop_q  <= cfg_data_i[GAIN_W-1:0];
        REG_INTEG_GAIN: igain_q <= cfg_data_i[GAIN_W-1:0];
        REG_DUTY_LIM:   dlim_q  <= cfg_data_i[LIM_W-1:0];
        REG_INTEG_LIM:  ilim_q  <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s0_rdy) s0_v_q <= s_axis_tvalid;
      if (s1_rdy) s1_v_q <= s0_v_q;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (out_rdy) out_v_q <= s2_v_q;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (s0_rdy && s_axis_tvalid) begin
      s0_cmd_q  <= cmd_e'(s_axis_tuser);
      s0_tgt_q  <= $signed(s_axis_tdata[15:0]);
      s0_meas_q <= $signed(s_axis_tdata[35:16]);
      s0_adv_q  <= s_axis_tdata[36];
    end
  end

  // Stage one: error, products and per-item control
  logic signed [ERR_W-1:0]  err;
  logic signed [KFF_W-1:0]  kff_prod;
  logic signed [PROD_W-1:0] prop_prod, iprod, iprod_b;
  logic signed [FFP_W-1:0]  icpt_term;
  logic                     tz, flip, ineg;

  assign tz   = (target_q == '0);
  assign flip = (s0_cmd_q == CMD_SET) &&
                (((target_q > 0) && (s0_tgt_q < 0)) || ((target_q < 0) && (s0_tgt_q > 0)));
  assign err  = ERR_W'($signed({target_q, 4'b0000})) - ERR_W'(s0_meas_q);

  assign kff_prod  = $signed({1'b0, kff_q}) * target_q;
  assign prop_prod = $signed({1'b0, prop_q}) * err;
  assign iprod     = $signed({1'b0, igain_q}) * err;

  // Step rounded to Q.16, ties away from zero
  assign ineg      = iprod[PROD_W-1];
  assign iprod_b   = iprod + $signed({{(PROD_W-4){1'b0}}, ~ineg, ineg, ineg, ineg});
  assign s1_step_d = STEP_W'(iprod_b >>> 4);

  // Intercept carries the target sign
  assign icpt_term = target_q[TGT_W-1] ? -FFP_W'($signed({1'b0, icpt_q, 4'b0000}))
                                       :  FFP_W'($signed({1'b0, icpt_q, 4'b0000}));
  assign s1_ffp_d  = icpt_term + (FFP_W'(kff_prod) <<< 4) + FFP_W'(prop_prod);

  always_comb begin
    s1_ctrl_d.upd     = (s0_cmd_q == CMD_UPDATE) && !tz;
    s1_ctrl_d.clr     = (s0_cmd_q == CMD_CLEAR) || flip || ((s0_cmd_q == CMD_UPDATE) && tz);
    s1_ctrl_d.adv     = s0_adv_q;
    s1_ctrl_d.err_pos = (err > 0);
    s1_ctrl_d.err_neg = err[ERR_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (s0_go && (s0_cmd_q == CMD_SET)) begin
      target_q <= s0_tgt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_go) begin
      s1_ctrl_q <= s1_ctrl_d;
      s1_ffp_q  <= s1_ffp_d;
      s1_step_q <= s1_step_d;
    end
  end

  // Stage two: integrator loop
  wsff_pi_integ u_integ (
    .integ_i       (integ_q),
    .ffp_i         (s1_ffp_q),
    .step_i        (s1_step_q),
    .ctrl_i        (s1_ctrl_q),
    .duty_limit_i  (dlim_q),
    .integ_limit_i (ilim_q),
    .integ_o       (integ_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (s1_go) begin
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_upd_q   <= s1_ctrl_q.upd;
      s2_clr_q   <= s1_ctrl_q.clr;
      s2_ffp_q   <= s1_ffp_q;
      s2_integ_q <= integ_d;
    end
  end

  // Stage three: final sum, flag, rounding and clamp
  logic signed [SUM_W-1:0] raw, raw_b, rnd, dl20, dl;
  logic                    rneg, sat_raw;

  assign raw     = SUM_W'(s2_ffp_q) + (SUM_W'(s2_integ_q) <<< 4);
  assign dl20    = $signed({{(SUM_W-LIM_W-20){1'b0}}, dlim_q, 20'b0});
  assign dl      = $signed({{(SUM_W-LIM_W){1'b0}}, dlim_q});
  assign sat_raw = (raw > dl20) || (raw < -dl20);
  assign rneg    = raw[SUM_W-1];
  assign raw_b   = raw + $signed({{(SUM_W-20){1'b0}}, ~rneg, {19{rneg}}});
  assign rnd     = raw_b >>> 20;

  always_comb begin
    duty_d = duty_q;
    sat_d  = sat_q;
    if (s2_clr_q) begin
      duty_d = '0;
      sat_d  = 1'b0;
    end else if (s2_upd_q) begin
      sat_d = sat_raw;
      priority if (rnd > dl) begin
        duty_d = DUTY_W'(dl);
      end else if (rnd < -dl) begin
        duty_d = DUTY_W'(-dl);
      end else begin
        duty_d = DUTY_W'(rnd);
      end
    end
  end

  // Output register doubles as the held duty and flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q <= '0;
      sat_q  <= 1'b0;
    end else if (s2_go) begin
      duty_q <= duty_d;
      sat_q  <= sat_d;
    end
  end

endmodule
